>>> design/iac_pkg.sv
// ----------------------------------------------------------------------------
// Intrusion alarm controller package
// Shared types, register indexes, key codes and reset values.
// ----------------------------------------------------------------------------
package iac_pkg;

    localparam int TIMER_BITS_DEF = 16;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int ROUND_W    = 3;
    localparam int PIN_PROG_W = 3;

    localparam logic [15:0] EXIT_DELAY_RST  = 16'd5000;
    localparam logic [15:0] ENTRY_DELAY_RST = 16'd5000;
    localparam logic [15:0] SIREN_TIME_RST  = 16'd5000;
    localparam logic [15:0] SLOW_BLINK_RST  = 16'd500;
    localparam logic [15:0] FAST_BLINK_RST  = 16'd150;
    localparam logic [2:0]  MAX_ROUNDS_RST  = 3'd3;
    localparam logic [15:0] PIN_CODE_RST    = 16'h1234;

    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_STAR      = 4'd10;
    localparam logic [3:0] KEY_HASH      = 4'd11;

    localparam logic [2:0] PIN_FIRST = 3'd1;
    localparam logic [2:0] PIN_LAST  = 3'd4;

    typedef enum logic [1:0] {
        MODE_DISARMED = 2'd0,
        MODE_ARMED    = 2'd1,
        MODE_ENTRY    = 2'd2,
        MODE_ALARM    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_EXIT_DELAY  = 3'd0,
        CFG_ENTRY_DELAY = 3'd1,
        CFG_SIREN_TIME  = 3'd2,
        CFG_SLOW_BLINK  = 3'd3,
        CFG_FAST_BLINK  = 3'd4,
        CFG_MAX_ROUNDS  = 3'd5,
        CFG_PIN_CODE    = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic       tick;
        logic       key_pressed;
        logic [3:0] key_code;
        logic       entry_door_opened;
        logic       other_door_open;
    } in_t;

    typedef struct packed {
        logic       led_on;
        logic       siren_on;
        mode_t      mode;
        logic       arming_pending;
        logic [2:0] rounds_done;
    } out_t;

endpackage

>>> design/intrusion_alarm_controller.sv
// ----------------------------------------------------------------------------
// Intrusion alarm controller
// Alarm mode sequencer with exit and entry delays, PIN entry, siren rounds
// and status LED blinking, one sample period per transaction.
// ----------------------------------------------------------------------------
// Each input transaction is one sample period and produces exactly one result
// transaction, which appears in the result register in the cycle after the input
// is accepted. A new input transaction can be accepted every cycle: in_ready
// is high whenever the result register is empty or is being read in the same
// cycle, so the throughput is one transaction per clock while results are
// taken, through the single result register stage. Configuration writes take
// effect at the next clock edge and are meant to be made while idle.
module intrusion_alarm_controller #(
    parameter int TIMER_BITS = iac_pkg::TIMER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [iac_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [iac_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  iac_pkg::in_t                      in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output iac_pkg::out_t                     out_data
);

    localparam int CMP_W = (TIMER_BITS > iac_pkg::CFG_W) ? TIMER_BITS : iac_pkg::CFG_W;
    localparam logic [TIMER_BITS-1:0] TMR_MAX = {TIMER_BITS{1'b1}};

    logic [15:0] exit_delay_reg, entry_delay_reg, siren_time_reg;
    logic [15:0] slow_blink_reg, fast_blink_reg, pin_code_reg;
    logic [2:0]  max_rounds_reg;

    iac_pkg::mode_t mode_reg, mode_next;
    logic [iac_pkg::PIN_PROG_W-1:0] pin_prog_reg, pin_prog_next;
    logic countdown_reg, countdown_next;
    logic [iac_pkg::ROUND_W-1:0] round_reg, round_next;
    logic [TIMER_BITS-1:0] exit_el_reg, exit_el_next;
    logic [TIMER_BITS-1:0] entry_el_reg, entry_el_next;
    logic [TIMER_BITS-1:0] siren_el_reg, siren_el_next;
    logic [TIMER_BITS-1:0] blink_el_reg, blink_el_next;
    logic led_reg, led_next;
    logic siren_reg, siren_next;

    logic           out_valid_reg;
    iac_pkg::out_t  out_data_reg;

    logic in_fire;
    logic [TIMER_BITS-1:0] exit_cnt, entry_cnt, siren_cnt, blink_cnt;
    logic exit_hit, entry_hit, siren_hit, slow_hit, fast_hit;
    logic key_star, key_hash, rounds_left;
    logic [iac_pkg::PIN_PROG_W-1:0] pin_prog_eff;
    logic [3:0] pin_want;
    logic digit_ok, pin_done, pin_adv;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exit_delay_reg  <= iac_pkg::EXIT_DELAY_RST;
            entry_delay_reg <= iac_pkg::ENTRY_DELAY_RST;
            siren_time_reg  <= iac_pkg::SIREN_TIME_RST;
            slow_blink_reg  <= iac_pkg::SLOW_BLINK_RST;
            fast_blink_reg  <= iac_pkg::FAST_BLINK_RST;
            max_rounds_reg  <= iac_pkg::MAX_ROUNDS_RST;
            pin_code_reg    <= iac_pkg::PIN_CODE_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                iac_pkg::CFG_EXIT_DELAY:  exit_delay_reg  <= cfg_wdata;
                iac_pkg::CFG_ENTRY_DELAY: entry_delay_reg <= cfg_wdata;
                iac_pkg::CFG_SIREN_TIME:  siren_time_reg  <= cfg_wdata;
                iac_pkg::CFG_SLOW_BLINK:  slow_blink_reg  <= cfg_wdata;
                iac_pkg::CFG_FAST_BLINK:  fast_blink_reg  <= cfg_wdata;
                iac_pkg::CFG_MAX_ROUNDS:  max_rounds_reg  <= cfg_wdata[2:0];
                iac_pkg::CFG_PIN_CODE:    pin_code_reg    <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Timers advance on a tick before any decision of the period is made.
    assign exit_cnt  = (in_data.tick && exit_el_reg != TMR_MAX) ?
                       exit_el_reg + 1'b1 : exit_el_reg;
    assign entry_cnt = (in_data.tick && entry_el_reg != TMR_MAX) ?
                       entry_el_reg + 1'b1 : entry_el_reg;
    assign siren_cnt = (in_data.tick && siren_el_reg != TMR_MAX) ?
                       siren_el_reg + 1'b1 : siren_el_reg;
    assign blink_cnt = (in_data.tick && blink_el_reg != TMR_MAX) ?
                       blink_el_reg + 1'b1 : blink_el_reg;

    assign exit_hit  = CMP_W'(exit_cnt)  >= CMP_W'(exit_delay_reg);
    assign entry_hit = CMP_W'(entry_cnt) >= CMP_W'(entry_delay_reg);
    assign siren_hit = CMP_W'(siren_cnt) >= CMP_W'(siren_time_reg);
    assign slow_hit  = CMP_W'(blink_cnt) >= CMP_W'(slow_blink_reg);
    assign fast_hit  = CMP_W'(blink_cnt) >= CMP_W'(fast_blink_reg);

    assign key_star    = in_data.key_pressed && in_data.key_code == iac_pkg::KEY_STAR;
    assign key_hash    = in_data.key_pressed && in_data.key_code == iac_pkg::KEY_HASH;
    assign rounds_left = round_reg < max_rounds_reg;

    assign pin_prog_eff = key_star ? iac_pkg::PIN_FIRST : pin_prog_reg;

    always_comb
    begin
        case (pin_prog_eff)
            3'd1:    pin_want = pin_code_reg[15:12];
            3'd2:    pin_want = pin_code_reg[11:8];
            3'd3:    pin_want = pin_code_reg[7:4];
            default: pin_want = pin_code_reg[3:0];
        endcase
    end

    assign digit_ok = in_data.key_pressed && in_data.key_code <= iac_pkg::KEY_DIGIT_MAX
                      && pin_prog_eff >= iac_pkg::PIN_FIRST
                      && pin_prog_eff <= iac_pkg::PIN_LAST
                      && in_data.key_code == pin_want;
    assign pin_done = digit_ok && pin_prog_eff == iac_pkg::PIN_LAST;
    assign pin_adv  = digit_ok && pin_prog_eff != iac_pkg::PIN_LAST;

    always_comb
    begin
        mode_next = mode_reg;
        unique case (mode_reg)
            iac_pkg::MODE_DISARMED:
            begin
                if (countdown_reg && exit_hit)
                begin
                    mode_next = iac_pkg::MODE_ARMED;
                end
            end
            iac_pkg::MODE_ARMED:
            begin
                if (pin_done)
                begin
                    mode_next = iac_pkg::MODE_DISARMED;
                end
                else if (in_data.other_door_open)
                begin
                    mode_next = iac_pkg::MODE_ALARM;
                end
                else if (in_data.entry_door_opened)
                begin
                    mode_next = iac_pkg::MODE_ENTRY;
                end
            end
            iac_pkg::MODE_ENTRY:
            begin
                if (pin_done)
                begin
                    mode_next = iac_pkg::MODE_DISARMED;
                end
                else if (entry_hit)
                begin
                    mode_next = iac_pkg::MODE_ALARM;
                end
            end
            iac_pkg::MODE_ALARM:
            begin
                if (pin_done)
                begin
                    mode_next = iac_pkg::MODE_DISARMED;
                end
                else if (rounds_left && siren_hit)
                begin
                    mode_next = iac_pkg::MODE_ARMED;
                end
            end
            default:
            begin
                mode_next = iac_pkg::MODE_DISARMED;
            end
        endcase
    end

    always_comb
    begin
        pin_prog_next  = pin_prog_eff;
        countdown_next = countdown_reg;
        round_next     = round_reg;
        exit_el_next   = exit_cnt;
        entry_el_next  = entry_cnt;
        siren_el_next  = siren_cnt;
        blink_el_next  = blink_cnt;
        led_next       = led_reg;
        siren_next     = siren_reg;
        unique case (mode_reg)
            iac_pkg::MODE_DISARMED:
            begin
                round_next = '0;
                if (countdown_reg && (exit_hit || in_data.key_pressed))
                begin
                    countdown_next = 1'b0;
                end
                if (!(countdown_reg && in_data.key_pressed) && key_hash)
                begin
                    countdown_next = 1'b1;
                    exit_el_next   = '0;
                end
            end
            iac_pkg::MODE_ARMED:
            begin
                if (slow_hit)
                begin
                    led_next      = !led_reg;
                    blink_el_next = '0;
                end
                if (in_data.other_door_open)
                begin
                    siren_el_next = '0;
                    led_next      = 1'b0;
                end
                else if (in_data.entry_door_opened)
                begin
                    entry_el_next = '0;
                end
                if (pin_adv)
                begin
                    pin_prog_next = pin_prog_eff + 1'b1;
                end
                if (pin_done)
                begin
                    led_next      = 1'b0;
                    pin_prog_next = iac_pkg::PIN_FIRST;
                end
            end
            iac_pkg::MODE_ENTRY:
            begin
                if (fast_hit)
                begin
                    led_next      = !led_reg;
                    blink_el_next = '0;
                end
                if (pin_adv)
                begin
                    pin_prog_next = pin_prog_eff + 1'b1;
                end
                if (pin_done)
                begin
                    led_next      = 1'b0;
                    pin_prog_next = iac_pkg::PIN_FIRST;
                end
                else if (entry_hit)
                begin
                    siren_el_next = '0;
                end
            end
            iac_pkg::MODE_ALARM:
            begin
                if (rounds_left)
                begin
                    led_next   = 1'b0;
                    siren_next = 1'b1;
                    if (siren_hit)
                    begin
                        siren_next = 1'b0;
                        round_next = round_reg + 1'b1;
                    end
                end
                else if (fast_hit)
                begin
                    led_next      = !led_reg;
                    blink_el_next = '0;
                end
                if (pin_adv)
                begin
                    pin_prog_next = pin_prog_eff + 1'b1;
                end
                if (pin_done)
                begin
                    siren_next    = 1'b0;
                    led_next      = 1'b0;
                    pin_prog_next = iac_pkg::PIN_FIRST;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= iac_pkg::MODE_DISARMED;
            pin_prog_reg  <= iac_pkg::PIN_FIRST;
            countdown_reg <= 1'b0;
            round_reg     <= '0;
            exit_el_reg   <= '0;
            entry_el_reg  <= '0;
            siren_el_reg  <= '0;
            blink_el_reg  <= '0;
            led_reg       <= 1'b0;
            siren_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg      <= mode_next;
                pin_prog_reg  <= pin_prog_next;
                countdown_reg <= countdown_next;
                round_reg     <= round_next;
                exit_el_reg   <= exit_el_next;
                entry_el_reg  <= entry_el_next;
                siren_el_reg  <= siren_el_next;
                blink_el_reg  <= blink_el_next;
                led_reg       <= led_next;
                siren_reg     <= siren_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_data_reg.led_on         <= led_next;
            out_data_reg.siren_on       <= siren_next;
            out_data_reg.mode           <= mode_next;
            out_data_reg.arming_pending <= countdown_next;
            out_data_reg.rounds_done    <= round_next;
        end
    end

    // The siren can only be driven while the alarm is active.
    a_siren_in_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        siren_reg |-> mode_reg == iac_pkg::MODE_ALARM)
        else $error("siren driven outside alarm mode");

    // The exit countdown only runs while disarmed.
    a_countdown_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        countdown_reg |-> mode_reg == iac_pkg::MODE_DISARMED)
        else $error("exit countdown running outside disarmed mode");

    // PIN progress always points at one of the four digits.
    a_pin_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
        pin_prog_reg >= iac_pkg::PIN_FIRST && pin_prog_reg <= iac_pkg::PIN_LAST)
        else $error("PIN progress out of range");

    // Input is only held off while a result waits to be taken.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg && !out_ready)
        else $error("input stalled without a pending result");

    // An accepted transaction always leaves a result behind.
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted transaction produced no result");

endmodule

>>> tb/intrusion_alarm_controller_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Intrusion alarm controller testbench
// Drives sample periods through the valid/ready input channel and checks every
// status transaction against a local prediction of the alarm sequencer. The
// run covers several register settings, from all zero to all maximum, plus a
// quiet stretch that is armed with a zero exit delay.
// ----------------------------------------------------------------------------
module intrusion_alarm_controller_test;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_AT = 60;
    localparam int HOLD_LEN = 300;
    localparam logic [iac_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [iac_pkg::TIMER_BITS_DEF-1:0] TIMER_TOP = '1;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wen = 1'b0;
    logic [iac_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
    logic [iac_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    iac_pkg::in_t                  in_data = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    iac_pkg::out_t                 out_data;

    iac_pkg::mode_t                     alarm_mode;
    logic [iac_pkg::PIN_PROG_W-1:0]     pin_pos;
    bit                                 exit_pending;
    logic [iac_pkg::ROUND_W-1:0]        rounds_sounded;
    logic [iac_pkg::TIMER_BITS_DEF-1:0] exit_t, entry_t, siren_t, blink_t;
    bit                                 led_lvl, siren_lvl;

    logic [iac_pkg::CFG_W-1:0]   exit_dly, entry_dly, siren_dur, slow_per, fast_per, pin_val;
    logic [iac_pkg::ROUND_W-1:0] round_limit;

    iac_pkg::in_t  sample_queue[$];
    iac_pkg::out_t awaited_status[$];
    int   mismatches = 0;
    int   results_seen = 0;
    int   cycles = 0;
    int   send_gap = 0;
    int   rx_stall = 0;
    int   hold_left = 0;
    int   phase_items = 0;
    bit   offer_open;
    bit   steady = 1'b0;

    intrusion_alarm_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void reset_alarm_model();
        exit_dly = iac_pkg::EXIT_DELAY_RST;
        entry_dly = iac_pkg::ENTRY_DELAY_RST;
        siren_dur = iac_pkg::SIREN_TIME_RST;
        slow_per = iac_pkg::SLOW_BLINK_RST;
        fast_per = iac_pkg::FAST_BLINK_RST;
        round_limit = iac_pkg::MAX_ROUNDS_RST;
        pin_val = iac_pkg::PIN_CODE_RST;
        alarm_mode = iac_pkg::MODE_DISARMED;
        pin_pos = iac_pkg::PIN_FIRST;
        exit_pending = 1'b0;
        rounds_sounded = '0;
        exit_t = '0;
        entry_t = '0;
        siren_t = '0;
        blink_t = '0;
        led_lvl = 1'b0;
        siren_lvl = 1'b0;
    endfunction

    function automatic logic [iac_pkg::TIMER_BITS_DEF-1:0] sat_inc(
        logic [iac_pkg::TIMER_BITS_DEF-1:0] c);
        return (c == TIMER_TOP) ? c : c + 1'b1;
    endfunction

    function automatic void toggle_led(logic [iac_pkg::CFG_W-1:0] period);
        if (blink_t >= period)
        begin
            led_lvl = !led_lvl;
            blink_t = '0;
        end
    endfunction

    function automatic void go_disarmed();
        led_lvl = 1'b0;
        alarm_mode = iac_pkg::MODE_DISARMED;
        pin_pos = iac_pkg::PIN_FIRST;
    endfunction

    function automatic bit pin_complete(iac_pkg::in_t x);
        logic [3:0] want;
        int         shift;
        if (!x.key_pressed || x.key_code > iac_pkg::KEY_DIGIT_MAX ||
            pin_pos < iac_pkg::PIN_FIRST || pin_pos > iac_pkg::PIN_LAST)
            return 1'b0;
        shift = 4 * (int'(iac_pkg::PIN_LAST) - int'(pin_pos));
        want = 4'(pin_val >> shift);
        if (x.key_code != want)
            return 1'b0;
        if (pin_pos == iac_pkg::PIN_LAST)
            return 1'b1;
        pin_pos = pin_pos + 1'b1;
        return 1'b0;
    endfunction

    function automatic iac_pkg::out_t alarm_step(iac_pkg::in_t x);
        iac_pkg::out_t r;
        bit            cancelled;
        cancelled = 1'b0;
        if (x.tick)
        begin
            exit_t = sat_inc(exit_t);
            entry_t = sat_inc(entry_t);
            siren_t = sat_inc(siren_t);
            blink_t = sat_inc(blink_t);
        end
        if (x.key_pressed && x.key_code == iac_pkg::KEY_STAR)
            pin_pos = iac_pkg::PIN_FIRST;
        case (alarm_mode)
            iac_pkg::MODE_DISARMED:
            begin
                rounds_sounded = '0;
                if (exit_pending)
                begin
                    if (exit_t >= exit_dly)
                    begin
                        alarm_mode = iac_pkg::MODE_ARMED;
                        exit_pending = 1'b0;
                    end
                    if (x.key_pressed)
                    begin
                        exit_pending = 1'b0;
                        cancelled = 1'b1;
                    end
                end
                if (!cancelled && x.key_pressed && x.key_code == iac_pkg::KEY_HASH)
                begin
                    exit_pending = 1'b1;
                    exit_t = '0;
                end
            end
            iac_pkg::MODE_ARMED:
            begin
                toggle_led(slow_per);
                if (x.other_door_open)
                begin
                    siren_t = '0;
                    led_lvl = 1'b0;
                    alarm_mode = iac_pkg::MODE_ALARM;
                end
                else if (x.entry_door_opened)
                begin
                    entry_t = '0;
                    alarm_mode = iac_pkg::MODE_ENTRY;
                end
                if (pin_complete(x))
                    go_disarmed();
            end
            iac_pkg::MODE_ENTRY:
            begin
                toggle_led(fast_per);
                if (pin_complete(x))
                    go_disarmed();
                else if (entry_t >= entry_dly)
                begin
                    siren_t = '0;
                    alarm_mode = iac_pkg::MODE_ALARM;
                end
            end
            default:
            begin
                if (rounds_sounded < round_limit)
                begin
                    led_lvl = 1'b0;
                    siren_lvl = 1'b1;
                    if (siren_t >= siren_dur)
                    begin
                        siren_lvl = 1'b0;
                        rounds_sounded = rounds_sounded + 1'b1;
                        alarm_mode = iac_pkg::MODE_ARMED;
                    end
                end
                else
                begin
                    toggle_led(fast_per);
                end
                if (pin_complete(x))
                begin
                    siren_lvl = 1'b0;
                    go_disarmed();
                end
            end
        endcase
        r.led_on = led_lvl;
        r.siren_on = siren_lvl;
        r.mode = alarm_mode;
        r.arming_pending = exit_pending;
        r.rounds_done = rounds_sounded;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void queue_item(bit t, bit p, logic [3:0] k, bit e, bit o);
        iac_pkg::in_t x;
        x.tick = t;
        x.key_pressed = p;
        x.key_code = k;
        x.entry_door_opened = e;
        x.other_door_open = o;
        sample_queue.push_back(x);
        phase_items++;
    endfunction

    function automatic bit some_tick();
        return $urandom_range(0, 9) < 8;
    endfunction

    function automatic void queue_quiet();
        queue_item(some_tick(), 1'b0, 4'($urandom), 1'b0, 1'b0);
    endfunction

    function automatic void queue_key(logic [3:0] k);
        queue_item(some_tick(), 1'b1, k, 1'b0, 1'b0);
    endfunction

    function automatic void queue_pin();
        if ($urandom_range(0, 9) == 0)
            queue_key(iac_pkg::KEY_STAR);
        for (int d = 3; d >= 0; d--)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_key(4'($urandom_range(0, 9)));
            repeat ($urandom_range(0, 2))
                queue_quiet();
            queue_key(pin_val[4*d +: 4]);
        end
    endfunction

    function automatic void queue_scenario();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 20)
        begin
            queue_key(iac_pkg::KEY_HASH);
            repeat ($urandom_range(0, 12))
                queue_quiet();
        end
        else if (kind < 45)
            queue_pin();
        else if (kind < 60)
            queue_item(some_tick(), 1'b0, 4'($urandom), 1'b1, 1'b0);
        else if (kind < 70)
            queue_item(some_tick(), 1'b0, 4'($urandom), 1'($urandom_range(0, 1)), 1'b1);
        else if (kind < 90)
        begin
            repeat ($urandom_range(1, 15))
                queue_quiet();
        end
        else
            queue_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 4'($urandom),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    task automatic queue_random(int count);
        phase_items = 0;
        while (phase_items < count)
            queue_scenario();
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (sample_queue.size() != 0 || in_valid || awaited_status.size() != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [iac_pkg::CFG_IDX_W-1:0] idx,
                             logic [iac_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            iac_pkg::CFG_EXIT_DELAY:  exit_dly = val;
            iac_pkg::CFG_ENTRY_DELAY: entry_dly = val;
            iac_pkg::CFG_SIREN_TIME:  siren_dur = val;
            iac_pkg::CFG_SLOW_BLINK:  slow_per = val;
            iac_pkg::CFG_FAST_BLINK:  fast_per = val;
            iac_pkg::CFG_MAX_ROUNDS:  round_limit = val[iac_pkg::ROUND_W-1:0];
            iac_pkg::CFG_PIN_CODE:    pin_val = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    task automatic set_regs(logic [iac_pkg::CFG_W-1:0] ex, logic [iac_pkg::CFG_W-1:0] en,
                            logic [iac_pkg::CFG_W-1:0] sr, logic [iac_pkg::CFG_W-1:0] sl,
                            logic [iac_pkg::CFG_W-1:0] fa, logic [iac_pkg::CFG_W-1:0] mr,
                            logic [iac_pkg::CFG_W-1:0] pc);
        write_reg(iac_pkg::CFG_EXIT_DELAY, ex);
        write_reg(iac_pkg::CFG_ENTRY_DELAY, en);
        write_reg(iac_pkg::CFG_SIREN_TIME, sr);
        write_reg(iac_pkg::CFG_SLOW_BLINK, sl);
        write_reg(iac_pkg::CFG_FAST_BLINK, fa);
        write_reg(iac_pkg::CFG_MAX_ROUNDS, mr);
        write_reg(iac_pkg::CFG_PIN_CODE, pc);
    endtask

    function automatic logic [iac_pkg::CFG_W-1:0] random_pin();
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    task automatic check_status(iac_pkg::out_t got);
        iac_pkg::out_t want;
        if (awaited_status.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: status transaction with none expected: %p", $time, got);
        end
        else
        begin
            want = awaited_status.pop_front();
            if (got.led_on !== want.led_on || got.siren_on !== want.siren_on ||
                got.mode !== want.mode || got.arming_pending !== want.arming_pending ||
                got.rounds_done !== want.rounds_done)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected %b %b %0d %b %0d, got %b %b %0d %b %0d",
                             $time, want.led_on, want.siren_on, want.mode,
                             want.arming_pending, want.rounds_done, got.led_on,
                             got.siren_on, got.mode, got.arming_pending, got.rounds_done);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            offer_open = !in_valid;
            if (in_valid && in_ready)
            begin
                awaited_status.push_back(alarm_step(in_data));
                offer_open = 1'b1;
            end
            if (offer_open)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (sample_queue.size() > 0)
                begin
                    in_data <= sample_queue.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_status(out_data);
                results_seen++;
                if (results_seen == HOLD_AT)
                    hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                rx_stall = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        reset_alarm_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults: key handling while disarmed.
        queue_item(1'b1, 1'b0, 4'hF, 1'b1, 1'b1);
        queue_item(1'b0, 1'b1, iac_pkg::KEY_HASH, 1'b0, 1'b0);
        queue_item(1'b1, 1'b1, 4'hC, 1'b1, 1'b1);
        queue_item(1'b0, 1'b1, iac_pkg::KEY_STAR, 1'b0, 1'b0);
        wait_idle();

        set_regs(16'd3, 16'd4, 16'd3, 16'd2, 16'd1, 16'd2, 16'h1234);
        // Arm with a key pressed on the expiring item, then disarm during entry
        // delay with the last digit landing on the timeout.
        queue_item(1'b1, 1'b1, iac_pkg::KEY_HASH, 1'b0, 1'b0);
        queue_item(1'b1, 1'b0, 4'd0, 1'b0, 1'b0);
        queue_item(1'b1, 1'b0, 4'd0, 1'b0, 1'b0);
        queue_item(1'b1, 1'b1, 4'd5, 1'b0, 1'b0);
        queue_item(1'b1, 1'b0, 4'd0, 1'b1, 1'b0);
        queue_item(1'b0, 1'b1, 4'd1, 1'b0, 1'b0);
        queue_item(1'b0, 1'b1, 4'd9, 1'b0, 1'b0);
        queue_item(1'b0, 1'b1, 4'd2, 1'b0, 1'b0);
        queue_item(1'b0, 1'b1, 4'd3, 1'b0, 1'b0);
        repeat (3) queue_item(1'b1, 1'b0, 4'd0, 1'b0, 1'b0);
        queue_item(1'b1, 1'b1, 4'd4, 1'b0, 1'b0);
        queue_item(1'b1, 1'b1, iac_pkg::KEY_HASH, 1'b0, 1'b0);
        repeat (3) queue_item(1'b1, 1'b0, 4'd0, 1'b0, 1'b0);
        queue_item(1'b1, 1'b0, 4'd0, 1'b0, 1'b1);
        repeat (4) queue_item(1'b1, 1'b0, 4'd0, 1'b0, 1'b0);
        queue_random(150);
        wait_idle();

        steady = 1'b1;
        set_regs('0, '0, '0, '0, '0, '0, '0);
        queue_random(130);
        wait_idle();
        steady = 1'b0;

        set_regs('1, '1, '1, '1, '1, '1, 16'h9999);
        queue_random(80);
        wait_idle();

        repeat (2)
        begin
            set_regs(16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                     16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)),
                     16'($urandom_range(0, 8)), 16'($urandom_range(0, 7)),
                     random_pin());
            queue_random(120);
            wait_idle();
        end

        // A PIN nibble above nine can never be matched.
        set_regs(16'd1, 16'd2, 16'd1, 16'd0, 16'd3, 16'd1, 16'h12A4);
        write_reg(CFG_UNUSED, 16'($urandom));
        queue_random(100);
        wait_idle();

        // Quiet stretch, then arming with a zero exit delay.
        steady = 1'b1;
        set_regs(16'd0, '1, '1, '1, '1, 16'd7, 16'h1234);
        queue_item(1'b0, 1'b1, iac_pkg::KEY_STAR, 1'b0, 1'b0);
        queue_pin();
        repeat (60) queue_item(1'b1, 1'b0, 4'($urandom), 1'b0, 1'b0);
        queue_item(1'b1, 1'b1, iac_pkg::KEY_HASH, 1'b0, 1'b0);
        repeat (3) queue_item(1'b1, 1'b0, 4'd0, 1'b0, 1'b0);
        queue_random(30);
        wait_idle();
        steady = 1'b0;

        repeat (8) @(posedge clk);
        if (mismatches == 0 && awaited_status.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> intrusion_alarm_controller.f
design/iac_pkg.sv
design/intrusion_alarm_controller.sv
tb/intrusion_alarm_controller_test.sv
